// File: hdl/agpb_pkg.sv
// Shared types, constants and lookup functions of the antialiased glyph pixel blender.
// Used by every module of the block; depends on nothing else.
package agpb_pkg;

  // Limits of the glyph in pixels.
  localparam int unsigned MAX_GLYPH_WIDTH  = 128;
  localparam int unsigned MAX_GLYPH_HEIGHT = 128;

  // Reciprocal multiplication: floor(x / m) = (x * R) >> RECIP_SHIFT for every
  // product x below 2^14 and every coverage maximum m up to 255.
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned PROD_W      = 14;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_FG_COLOR         = 3'd0,
    REG_BG_COLOR         = 3'd1,
    REG_TRANSPARENT_MODE = 3'd2,
    REG_BITS_PER_PIXEL   = 3'd3,
    REG_GLYPH_WIDTH      = 3'd4
  } cfg_reg_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SPLIT = 1'b1
  } ctrl_state_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        transparent_mode;
    logic [3:0]  bits_per_pixel;
    logic [7:0]  glyph_width;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;   // take the offered item and advance the counters
    logic       issue;  // send coverage value 'step' into the blend pipeline
    logic [2:0] step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       adv;       // blend pipeline moves this cycle
    logic [3:0] per_byte;  // coverage values in one byte
  } dp_status_t;

  // Largest coverage value, 2^bpp - 1, for a bpp already limited to 1..8.
  function automatic logic [7:0] cov_max(input logic [3:0] bpp);
    logic [7:0] m;
    case (bpp)
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd3:    m = 8'h07;
      4'd4:    m = 8'h0f;
      4'd5:    m = 8'h1f;
      4'd6:    m = 8'h3f;
      4'd7:    m = 8'h7f;
      default: m = 8'hff;
    endcase
    return m;
  endfunction

  // Coverage values in one byte, floor(8 / bpp).
  function automatic logic [3:0] pixels_per_byte(input logic [3:0] bpp);
    logic [3:0] n;
    case (bpp)
      4'd1:    n = 4'd8;
      4'd2:    n = 4'd4;
      4'd3:    n = 4'd2;
      4'd4:    n = 4'd2;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // ceil(2^RECIP_SHIFT / (2^bpp - 1)).
  function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] bpp);
    logic [RECIP_W-1:0] r;
    case (bpp)
      4'd1:    r = RECIP_W'(4194304);
      4'd2:    r = RECIP_W'(1398102);
      4'd3:    r = RECIP_W'(599187);
      4'd4:    r = RECIP_W'(279621);
      4'd5:    r = RECIP_W'(135301);
      4'd6:    r = RECIP_W'(66577);
      4'd7:    r = RECIP_W'(33027);
      default: r = RECIP_W'(16449);
    endcase
    return r;
  endfunction

endpackage

// File: hdl/antialiased_glyph_pixel_blender.sv
// Top level of the antialiased glyph pixel blender: stream ports, configuration port,
// register bank, controller and datapath. Depends on agpb_pkg and the agpb_* modules.
//
// Each input item is one packed glyph bitmap byte; it is split into floor(8/bpp)
// coverage values, most significant first, and each value that lands inside the glyph
// width (and is not zero in transparent mode) yields one blended RGB565 pixel with its
// column and row. An item is taken while the controller is idle, then it goes one step
// per coverage value through the shared blend pipeline, whatever the number of pixels
// it gives; the next item waits for its last step. Pixels pass stage 1, stage 2 and
// the output register; a stalled output holds the whole blend pipeline and the steps.
// The last pixel of each item carries tlast. No clearing pass follows reset.
module antialiased_glyph_pixel_blender (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] bitmap_byte
  input  logic        in_tuser,   // [0] glyph_start
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] pixel_color, [22:16] pixel_column,
                                  // [29:23] pixel_row, [31:30] zero
  output logic        out_tlast,  // last_of_byte
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  agpb_pkg::cfg_t       cfg;
  agpb_pkg::ctrl_cmd_t  cmd;
  agpb_pkg::dp_status_t status;
  logic [15:0]          pixel_color;
  logic [6:0]           pixel_column;
  logic [6:0]           pixel_row;

  agpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  agpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  agpb_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .in_byte    (in_tdata),
    .in_start   (in_tuser),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_color  (pixel_color),
    .out_column (pixel_column),
    .out_row    (pixel_row),
    .out_last   (out_tlast)
  );

  // Pack the pixel fields, first field in the lowest bits.
  assign out_tdata = {2'b00, pixel_row, pixel_column, pixel_color};

endmodule

// File: hdl/agpb_cfg_regs.sv
// Configuration register bank of the glyph pixel blender.
// Depends on agpb_pkg for the register indexes and the cfg_t record.
module agpb_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output agpb_pkg::cfg_t    cfg
);

  agpb_pkg::cfg_t cfg_r;
  agpb_pkg::cfg_t cfg_nxt;

  // Decode the write; an index beyond the list changes nothing.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (agpb_pkg::cfg_reg_t'(cfg_index))
        agpb_pkg::REG_FG_COLOR:         cfg_nxt.fg_color         = cfg_wdata;
        agpb_pkg::REG_BG_COLOR:         cfg_nxt.bg_color         = cfg_wdata;
        agpb_pkg::REG_TRANSPARENT_MODE: cfg_nxt.transparent_mode = cfg_wdata[0];
        agpb_pkg::REG_BITS_PER_PIXEL:   cfg_nxt.bits_per_pixel   = cfg_wdata[3:0];
        agpb_pkg::REG_GLYPH_WIDTH:      cfg_nxt.glyph_width      = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_color         <= 16'hffff;
      cfg_r.bg_color         <= 16'h0000;
      cfg_r.transparent_mode <= 1'b0;
      cfg_r.bits_per_pixel   <= 4'd4;
      cfg_r.glyph_width      <= 8'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/agpb_ctrl.sv
// Controller of the glyph pixel blender: takes an item, then steps through its
// coverage values one per pipeline advance. Depends on agpb_pkg.
module agpb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  agpb_pkg::dp_status_t   status,
  output agpb_pkg::ctrl_cmd_t    cmd
);

  agpb_pkg::ctrl_state_t state_r, state_nxt;
  logic [2:0]            step_r, step_nxt;
  logic                  last_step;

  assign last_step = (step_r == 3'(status.per_byte - 4'd1));

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      agpb_pkg::ST_IDLE: begin
        step_nxt = 3'd0;
        if (in_tvalid) begin
          state_nxt = agpb_pkg::ST_SPLIT;
        end
      end
      agpb_pkg::ST_SPLIT: begin
        if (status.adv) begin
          if (last_step) begin
            state_nxt = agpb_pkg::ST_IDLE;
            step_nxt  = 3'd0;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = agpb_pkg::ST_IDLE;
        step_nxt  = 3'd0;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.issue = 1'b0;
    cmd.step  = step_r;
    case (state_r)
      agpb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      agpb_pkg::ST_SPLIT: begin
        cmd.issue = status.adv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= agpb_pkg::ST_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: hdl/agpb_datapath.sv
// Datapath of the glyph pixel blender: glyph counters, item register and the three-stage
// stallable blend pipeline whose last stage is the output register. Depends on agpb_pkg.
module agpb_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  agpb_pkg::cfg_t         cfg,
  input  agpb_pkg::ctrl_cmd_t    cmd,
  output agpb_pkg::dp_status_t   status,
  input  logic [7:0]             in_byte,
  input  logic                   in_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            out_color,
  output logic [6:0]             out_column,
  output logic [6:0]             out_row,
  output logic                   out_last
);

  localparam int unsigned PW = agpb_pkg::PROD_W;
  localparam int unsigned MW = agpb_pkg::PROD_W + agpb_pkg::RECIP_W;

  // Coverage value at position idx of a byte, counted from the most significant end.
  function automatic logic [7:0] cov_at(input logic [7:0] b, input logic [2:0] idx,
                                        input logic [2:0] top, input logic [3:0] bpp,
                                        input logic [7:0] m);
    logic [2:0] diff;
    logic [6:0] amt;
    diff = top - idx;
    amt  = 7'(diff) * 7'(bpp);
    return (b >> amt[2:0]) & m;
  endfunction

  // Effective configuration with out-of-range values clamped.
  logic [3:0]                   bpp;
  logic [7:0]                   width;
  logic [7:0]                   cmax;
  logic [3:0]                   per_byte;
  logic [2:0]                   top_idx;
  logic [agpb_pkg::RECIP_W-1:0] recip;
  logic [8:0]                   row_bytes;
  logic [11:0]                  row_bits;

  always_comb begin
    if (cfg.bits_per_pixel == 4'd0) begin
      bpp = 4'd1;
    end else if (cfg.bits_per_pixel > 4'd8) begin
      bpp = 4'd8;
    end else begin
      bpp = cfg.bits_per_pixel;
    end
    if (cfg.glyph_width == 8'd0) begin
      width = 8'd1;
    end else if (cfg.glyph_width > 8'(agpb_pkg::MAX_GLYPH_WIDTH)) begin
      width = 8'(agpb_pkg::MAX_GLYPH_WIDTH);
    end else begin
      width = cfg.glyph_width;
    end
    cmax      = agpb_pkg::cov_max(bpp);
    per_byte  = agpb_pkg::pixels_per_byte(bpp);
    top_idx   = 3'(per_byte - 4'd1);
    recip     = agpb_pkg::recip_of(bpp);
    row_bits  = 12'(width) * 12'(bpp) + 12'd7;
    row_bytes = row_bits[11:3];
  end

  // Pipeline advance: the output register is empty or is being taken.
  logic adv;
  logic s3_valid_r;
  assign adv             = !s3_valid_r || out_ready;
  assign status.adv      = adv;
  assign status.per_byte = per_byte;

  // Glyph counters and the item register, all updated when an item is taken.
  logic [7:0] column_count_r, column_count_nxt;
  logic [7:0] byte_in_row_r,  byte_in_row_nxt;
  logic [7:0] row_count_r,    row_count_nxt;
  logic [7:0] byte_r;
  logic [7:0] col_base_r;
  logic [6:0] row_base_r;
  logic [7:0] mask_r, mask_nxt;
  logic [7:0] col_base, bir_base, row_base;
  logic [7:0] room, n_cols, bir_inc;

  always_comb begin
    col_base = in_start ? 8'd0 : column_count_r;
    bir_base = in_start ? 8'd0 : byte_in_row_r;
    row_base = in_start ? 8'd0 : row_count_r;

    // One emit bit per coverage position, most significant position first.
    for (int i = 0; i < 8; i++) begin
      mask_nxt[i] = (4'(i) < per_byte) && ((9'(col_base) + 9'(i)) < 9'(width)) &&
                    !(cfg.transparent_mode &&
                      (cov_at(in_byte, 3'(i), top_idx, bpp, cmax) == 8'd0));
    end

    // Non-padding positions advance the column.
    room = width - col_base;
    if (col_base >= width) begin
      n_cols = 8'd0;
    end else if (room < 8'(per_byte)) begin
      n_cols = room;
    end else begin
      n_cols = 8'(per_byte);
    end

    bir_inc = bir_base + 8'd1;
    if (9'(bir_inc) >= row_bytes) begin
      byte_in_row_nxt  = 8'd0;
      column_count_nxt = 8'd0;
      row_count_nxt    = (row_base < 8'(agpb_pkg::MAX_GLYPH_HEIGHT - 1)) ?
                         row_base + 8'd1 : row_base;
    end else begin
      byte_in_row_nxt  = bir_inc;
      column_count_nxt = col_base + n_cols;
      row_count_nxt    = row_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= 8'd0;
      byte_in_row_r  <= 8'd0;
      row_count_r    <= 8'd0;
    end else if (cmd.load) begin
      column_count_r <= column_count_nxt;
      byte_in_row_r  <= byte_in_row_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r     <= in_byte;
      col_base_r <= col_base;
      row_base_r <= row_base[6:0];
      mask_r     <= mask_nxt;
    end
  end

  // Stage 1: coverage-weighted channel products.
  logic [7:0]  cov, inv_cov;
  logic [5:0]  fg_ch [3];
  logic [5:0]  bg_ch [3];
  logic        emit, emit_last;
  logic [7:0]  later_mask;

  assign fg_ch[0] = {1'b0, cfg.fg_color[15:11]};
  assign fg_ch[1] = cfg.fg_color[10:5];
  assign fg_ch[2] = {1'b0, cfg.fg_color[4:0]};
  assign bg_ch[0] = {1'b0, cfg.bg_color[15:11]};
  assign bg_ch[1] = cfg.bg_color[10:5];
  assign bg_ch[2] = {1'b0, cfg.bg_color[4:0]};

  assign cov        = cov_at(byte_r, cmd.step, top_idx, bpp, cmax);
  assign inv_cov    = cmax - cov;
  assign emit       = mask_r[cmd.step];
  assign later_mask = (mask_r >> cmd.step) >> 1;
  assign emit_last  = emit && (later_mask == 8'd0);

  logic          s1_valid_r;
  logic [PW-1:0] s1_pf_r [3];
  logic [PW-1:0] s1_pb_r [3];
  logic [7:0]    s1_col_r;
  logic [6:0]    s1_row_r;
  logic          s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= cmd.issue && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s1_pf_r[c] <= PW'(fg_ch[c]) * PW'(cov);
        s1_pb_r[c] <= PW'(bg_ch[c]) * PW'(inv_cov);
      end
      s1_col_r  <= col_base_r + 8'(cmd.step);
      s1_row_r  <= row_base_r;
      s1_last_r <= emit_last;
    end
  end

  // Stage 2: division by the coverage maximum through its reciprocal.
  logic          s2_valid_r;
  logic [5:0]    s2_qf_r [3];
  logic [5:0]    s2_qb_r [3];
  logic [7:0]    s2_col_r;
  logic [6:0]    s2_row_r;
  logic          s2_last_r;
  logic [MW-1:0] mul_f [3];
  logic [MW-1:0] mul_b [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mul_f[c] = MW'(s1_pf_r[c]) * MW'(recip);
      mul_b[c] = MW'(s1_pb_r[c]) * MW'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s2_qf_r[c] <= 6'(mul_f[c] >> agpb_pkg::RECIP_SHIFT);
        s2_qb_r[c] <= 6'(mul_b[c] >> agpb_pkg::RECIP_SHIFT);
      end
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: channel sums packed into RGB565 in the output register.
  logic [6:0]  sum_ch [3];
  logic [15:0] s3_color_r;
  logic [7:0]  s3_col_r;
  logic [6:0]  s3_row_r;
  logic        s3_last_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_ch[c] = 7'(s2_qf_r[c]) + 7'(s2_qb_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_color_r <= {sum_ch[0][4:0], sum_ch[1][5:0], sum_ch[2][4:0]};
      s3_col_r   <= s2_col_r;
      s3_row_r   <= s2_row_r;
      s3_last_r  <= s2_last_r;
    end
  end

  assign out_valid  = s3_valid_r;
  assign out_color  = s3_color_r;
  assign out_column = s3_col_r[6:0];
  assign out_row    = s3_row_r;
  assign out_last   = s3_last_r;

  // A coverage value is only issued while the pipeline moves.
  a_issue_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> adv)
    else $error("coverage value issued into a stalled pipeline");

  // Taking an item and stepping through the previous one never overlap.
  a_load_issue_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.issue))
    else $error("item taken while its predecessor is still being split");

  // A delivered pixel never lies in the padding beyond the glyph width.
  a_no_padding_out: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_col_r < width))
    else $error("padding pixel reached the output");

  // As a pixel that is not the last of its item moves on from stage 1, no new item is taken.
  a_last_then_new: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && !s1_last_r) |-> !cmd.load)
    else $error("item ended without a marked last pixel");

endmodule

// File: dv/tb_antialiased_glyph_pixel_blender.sv
// Self-checking testbench for the antialiased glyph pixel blender: it drives glyph bytes
// with bursts and gaps, and it checks every blended pixel against a predictor of its own.
// Depends on agpb_pkg and the antialiased_glyph_pixel_blender RTL.
module tb_antialiased_glyph_pixel_blender;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 410;
  localparam int unsigned HOLD_CYCLES   = 250;

  typedef struct {
    logic [7:0] bits;
    logic       start;
  } glyph_byte_t;

  typedef struct {
    logic [15:0] color;
    logic [6:0]  col;
    logic [6:0]  row;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] bitmap_byte
  logic        in_tuser = 1'b0;    // [0] glyph_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [15:0] colour, [22:16] column, [29:23] row, [31:30] zero
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_wdata = 16'h0000;

  // Settings and counters as the predictor sees them.
  logic [15:0] fg_now;
  logic [15:0] bg_now;
  logic        transparent_now;
  logic [3:0]  bpp_now;
  logic [7:0]  width_now;
  logic [7:0]  col_cnt;
  logic [7:0]  bytes_in_row;
  logic [7:0]  row_cnt;

  glyph_byte_t pend_q[$];
  pixel_t      pixel_q[$];

  int unsigned in_count = 0;
  int unsigned pixels_seen = 0;
  int unsigned errors = 0;
  int unsigned phases = 0;
  int unsigned holds = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_cyc = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 60;

  antialiased_glyph_pixel_blender uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Out-of-range bits per pixel and widths are clamped before use.
  function automatic int unsigned eff_bpp(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return 32'(v);
  endfunction

  function automatic int unsigned eff_width(input logic [7:0] v);
    if (v == 8'd0) return 1;
    if (32'(v) > agpb_pkg::MAX_GLYPH_WIDTH) return agpb_pkg::MAX_GLYPH_WIDTH;
    return 32'(v);
  endfunction

  function automatic int unsigned mix_channel(input int unsigned f, input int unsigned b,
                                              input int unsigned a, input int unsigned m);
    return (f * a) / m + (b * (m - a)) / m;
  endfunction

  function automatic logic [7:0] random_bits();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'($urandom) & 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  // Splits one byte into coverage values and queues the pixels it yields.
  task automatic predict_byte(input logic [7:0] bits, input logic start);
    int unsigned bpp, w, m, per, row_len, a, r, g, b;
    pixel_t px;
    pixel_t batch[$];
    bpp = eff_bpp(bpp_now);
    w = eff_width(width_now);
    m = (1 << bpp) - 1;
    per = 8 / bpp;
    row_len = (w * bpp + 7) / 8;
    if (start) begin
      col_cnt = 8'd0;
      bytes_in_row = 8'd0;
      row_cnt = 8'd0;
    end
    for (int k = per; k > 0; k--) begin
      a = (bits >> ((k - 1) * bpp)) & m;
      if (32'(col_cnt) < w) begin
        // Zero coverage in transparent mode still uses up a column.
        if (!(transparent_now && a == 0)) begin
          r = mix_channel(32'(fg_now[15:11]), 32'(bg_now[15:11]), a, m) & 'h1f;
          g = mix_channel(32'(fg_now[10:5]), 32'(bg_now[10:5]), a, m) & 'h3f;
          b = mix_channel(32'(fg_now[4:0]), 32'(bg_now[4:0]), a, m) & 'h1f;
          px.color = {r[4:0], g[5:0], b[4:0]};
          px.col = col_cnt[6:0];
          px.row = row_cnt[6:0];
          px.last = 1'b0;
          batch.push_back(px);
        end
        col_cnt = col_cnt + 8'd1;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pixel_q.push_back(batch[i]);
    // End of row; the row number saturates at the last row.
    bytes_in_row = bytes_in_row + 8'd1;
    if (32'(bytes_in_row) >= row_len) begin
      bytes_in_row = 8'd0;
      col_cnt = 8'd0;
      if (32'(row_cnt) < agpb_pkg::MAX_GLYPH_HEIGHT - 1) row_cnt = row_cnt + 8'd1;
    end
  endtask

  task automatic add_item(input logic [7:0] bits, input logic start);
    glyph_byte_t item;
    item.bits = bits;
    item.start = start;
    pend_q.push_back(item);
  endtask

  task automatic write_reg(input agpb_pkg::cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      agpb_pkg::REG_FG_COLOR:         fg_now = val;
      agpb_pkg::REG_BG_COLOR:         bg_now = val;
      agpb_pkg::REG_TRANSPARENT_MODE: transparent_now = val[0];
      agpb_pkg::REG_BITS_PER_PIXEL:   bpp_now = val[3:0];
      agpb_pkg::REG_GLYPH_WIDTH:      width_now = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] fg, input logic [15:0] bg, input logic tr,
                            input logic [3:0] bpp, input logic [7:0] w);
    write_reg(agpb_pkg::REG_FG_COLOR, fg);
    write_reg(agpb_pkg::REG_BG_COLOR, bg);
    write_reg(agpb_pkg::REG_TRANSPARENT_MODE, {15'd0, tr});
    write_reg(agpb_pkg::REG_BITS_PER_PIXEL, {12'd0, bpp});
    write_reg(agpb_pkg::REG_GLYPH_WIDTH, {8'd0, w});
    @(posedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // Waits until every item is taken and every pixel has arrived, then lets the
  // block finish any byte that yields no pixel.
  task automatic wait_idle();
    int unsigned n;
    do @(negedge clk); while (pend_q.size() != 0 || in_tvalid || pixel_q.size() != 0);
    n = 0;
    while (n < SETTLE_CYCLES) begin
      @(negedge clk);
      if (out_tready) n++;
    end
  endtask

  // Sender: bursts of random length with random gaps between them.
  always @(posedge clk) begin
    glyph_byte_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata, in_tuser);
        in_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          item = pend_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= item.bits;
          in_tuser <= item.start;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating stall pattern, with long hold-offs while the sender has plenty.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cyc++;
      if (hold_left == 0 && in_count >= next_hold_at && pend_q.size() >= 20) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 150;
        holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((rx_cyc / 80) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 9) < 7);
          2:       out_tready <= ((rx_cyc % 4) != 0);
          default: out_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Pixel checker: each pixel against the oldest expected one.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, got data %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata[15:0] !== want.color || out_tdata[22:16] !== want.col ||
            out_tdata[29:23] !== want.row || out_tdata[31:30] !== 2'b00 ||
            out_tlast !== want.last) begin
          errors++;
          $display({"%0t: pixel mismatch, expected colour %h col %0d row %0d last %b,",
                    " got colour %h col %0d row %0d last %b top %b"},
                   $time, want.color, want.col, want.row, want.last, out_tdata[15:0],
                   out_tdata[22:16], out_tdata[29:23], out_tlast, out_tdata[31:30]);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding.", cycles, pixel_q.size());
      $display("tb_antialiased_glyph_pixel_blender failed");
      $finish;
    end
  end

  // Stimulus: directed settings first, then a tall glyph, then random glyphs.
  initial begin
    int unsigned rand_items, ng, nb, row_len;
    logic [3:0] bpp_v;
    logic [7:0] w_v;
    logic [15:0] fg_v, bg_v;
    fg_now = 16'hffff;
    bg_now = 16'h0000;
    transparent_now = 1'b0;
    bpp_now = 4'd4;
    width_now = 8'd8;
    col_cnt = 8'd0;
    bytes_in_row = 8'd0;
    row_cnt = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: four bits per pixel, eight wide, so four bytes to a row.
    add_item(8'hf0, 1'b1);
    add_item(8'h0f, 1'b0);
    add_item(8'hff, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h12, 1'b0);
    add_item(8'h34, 1'b0);
    wait_idle();
    // One pixel wide, one bit, transparent: padding and bytes with no pixel.
    set_config(16'h0000, 16'hffff, 1'b1, 4'd1, 8'd1);
    add_item(8'h80, 1'b1);
    add_item(8'h7f, 1'b0);
    add_item(8'hff, 1'b0);
    wait_idle();
    // Eight bits per pixel at the widest glyph.
    set_config(16'hf800, 16'h07e0, 1'b0, 4'd8, 8'd128);
    add_item(8'h00, 1'b1);
    add_item(8'hff, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h01, 1'b0);
    wait_idle();
    // Three bits per pixel leaves the top two bits unused.
    set_config(16'h001f, 16'hffe0, 1'b1, 4'd3, 8'd5);
    add_item(8'hff, 1'b1);
    add_item(8'hc0, 1'b0);
    add_item(8'h3f, 1'b0);
    add_item(8'h00, 1'b0);
    wait_idle();
    // Zero bits per pixel and zero width are taken as one.
    set_config(16'hffff, 16'h0000, 1'b0, 4'd0, 8'd0);
    add_item(8'hff, 1'b1);
    add_item(8'h00, 1'b0);
    wait_idle();
    // Bits per pixel above eight and width above the maximum saturate.
    set_config(16'h1234, 16'hffff, 1'b0, 4'd15, 8'd200);
    add_item(8'ha5, 1'b1);
    add_item(8'h5a, 1'b0);
    wait_idle();

    // One byte per row for more rows than a glyph may have, so the row count saturates.
    set_config(16'($urandom), 16'($urandom), 1'b0, 4'd2, 8'd4);
    rand_items = 132;
    for (int i = 0; i < 132; i++) add_item(random_bits(), i == 0);
    wait_idle();

    // Random settings, each with a few glyphs; some start mid-glyph, some are cut short.
    while (rand_items < RANDOM_ITEMS) begin
      fg_v = ($urandom_range(0, 5) == 0) ? {16{1'($urandom)}} : 16'($urandom);
      bg_v = ($urandom_range(0, 5) == 0) ? {16{1'($urandom)}} : 16'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0:       bpp_v = 4'd1;
          1:       bpp_v = 4'd2;
          2:       bpp_v = 4'd4;
          default: bpp_v = 4'd8;
        endcase
      end else begin
        bpp_v = 4'($urandom_range(0, 15));
      end
      case ($urandom_range(0, 9))
        7, 8:    w_v = 8'($urandom_range(25, 128));
        9:       w_v = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(129, 255));
        default: w_v = 8'($urandom_range(1, 24));
      endcase
      set_config(fg_v, bg_v, 1'($urandom), bpp_v, w_v);
      row_len = (eff_width(w_v) * eff_bpp(bpp_v) + 7) / 8;
      ng = $urandom_range(1, 3);
      repeat (ng) begin
        nb = $urandom_range(1, 4) * row_len;
        if (nb > 36) nb = $urandom_range(12, 36);
        if ($urandom_range(0, 4) == 0) nb = $urandom_range(1, nb);
        for (int i = 0; i < nb; i++)
          add_item(random_bits(), (i == 0 && $urandom_range(0, 4) != 0) ||
                                  $urandom_range(0, 39) == 0);
        rand_items += nb;
      end
      wait_idle();
    end

    $display("Run covered %0d glyph bytes over %0d register settings and checked %0d pixels.",
             in_count, phases, pixels_seen);
    $display("Long output stalls: %0d, mismatches: %0d.", holds, errors);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("tb_antialiased_glyph_pixel_blender passed");
    end else begin
      $display("tb_antialiased_glyph_pixel_blender failed");
    end
    $finish;
  end

endmodule
